// File: design/gws_pkg.sv
// Shared types, constants and helpers of the grid word search counter.
package gws_pkg;

  // Default geometry of the line stores.
  localparam int DEFAULT_MAX_WIDTH = 256;

  // Smallest row width that the search window accepts.
  localparam int MIN_WIDTH = 4;

  // Column or row distance from the first to the last symbol of the word.
  localparam int WORD_REACH = 3;

  // Saturated value of the completed-row counter.
  localparam logic [1:0] ROWS_FULL = 2'd3;

  // Result counter limits.
  localparam int TOTAL_W = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // Register reset values.
  localparam logic [8:0] ROW_WIDTH_RST = 9'd140;
  localparam logic [7:0] FIRST_RST = 8'd88;
  localparam logic [7:0] SECOND_RST = 8'd77;
  localparam logic [7:0] THIRD_RST = 8'd65;
  localparam logic [7:0] FOURTH_RST = 8'd83;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ROW_WIDTH = 3'd0,
    REG_FIRST     = 3'd1,
    REG_SECOND    = 3'd2,
    REG_THIRD     = 3'd3,
    REG_FOURTH    = 3'd4
  } gws_reg_t;

  // The searched word, first symbol in the lowest byte.
  typedef struct packed {
    logic [7:0] fourth;
    logic [7:0] third;
    logic [7:0] second;
    logic [7:0] first;
  } gws_word_t;

  // Column taps read from the line stores for one cell.
  // above: byte 0 is the row above, byte 1 two rows up, byte 2 three rows up.
  // diag:  byte 0 is one up and one right, byte 1 two up and two right,
  //        byte 2 three up and three right.
  typedef struct packed {
    logic [23:0] above;
    logic [23:0] diag;
  } gws_taps_t;

  // Counts the word along a line of four cells, read forward and reversed.
  function automatic logic [1:0] both_ways(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d,
                                           input gws_word_t w);
    logic fwd;
    logic rev;
    fwd = (a == w.first) && (b == w.second) && (c == w.third) && (d == w.fourth);
    rev = (d == w.first) && (c == w.second) && (b == w.third) && (a == w.fourth);
    return {1'b0, fwd} + {1'b0, rev};
  endfunction

endpackage

// File: design/gws_line_store.sv
// Line stores holding the three previous rows and the pending anti-diagonals.
module gws_line_store #(
  parameter int MAX_WIDTH = gws_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [7:0]                   wr_symbol,
  output gws_pkg::gws_taps_t           taps
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] diag_mem [MAX_WIDTH];

  // Column history: push the new symbol in and age the older rows by one.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_col] <= {taps.above[15:0], wr_symbol};
    end
  end

  // The cell one row down and one column left sees this cell as its first
  // anti-diagonal neighbour, followed by the two nearest of this cell's own.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_col != '0)) begin
      diag_mem[wr_col - CW'(1)] <= {taps.diag[15:0], wr_symbol};
    end
  end

  // Registered reads, taken when a request enters the pipeline.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      taps.above <= line_mem[rd_addr];
      taps.diag  <= diag_mem[rd_addr];
    end
  end

endmodule

// File: design/grid_word_search_counter_unit.sv
// Top level of the grid word search counter.
//
// Symbols of a character grid arrive in raster order on the item channel
// (item_valid, item_stall, symbol, last_of_frame). For every symbol one
// result leaves on the result channel (result_valid, result_stall): the
// number of word occurrences that end at this cell in raster order, the
// running total of the frame and a frame-done mark on the last symbol.
// Occurrences are looked for in all eight directions and only where the
// whole line of four cells lies inside the grid.
// A request is taken in every cycle while item_stall is low. The line stores
// are read as a request enters the input stage, and its result is registered
// in the result register as it leaves that stage. The throughput of one
// request per cycle is set by the single read and write port of each line
// store, which are used once per symbol. Reset clears the column and row
// counters, the window, the total and the registers; the line stores need no
// clearing since rows are masked until three rows of the frame have been
// seen. When the receiver stalls, the result register holds and the input
// stage still takes one more request; after that item_stall rises until the
// result is taken. The user must write row width and word symbols on the APB
// port only while idle; the block does not enforce it.
module grid_word_search_counter_unit #(
  parameter int MAX_WIDTH = gws_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Symbol channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  symbol,
  input  logic        last_of_frame,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  matches_here,
  output logic [19:0] running_total,
  output logic        frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > 9) ? WW : 9;
  localparam int SW = EW + 1;

  // Configuration registers
  logic [8:0]         row_width;
  gws_pkg::gws_word_t word;

  // Position tracking, advanced as requests are accepted
  logic [CW-1:0] column_index;
  logic [1:0]    rows_seen;

  // Input stage
  logic          s1_valid;
  logic [7:0]    s1_symbol;
  logic          s1_last;
  logic [CW-1:0] s1_col;
  logic          s1_rows3;

  // Frame state, advanced as requests leave the input stage
  logic [7:0]                 window [4][4];
  logic [7:0]                 window_next [4][4];
  logic [gws_pkg::TOTAL_W-1:0] total_count;
  logic [gws_pkg::TOTAL_W-1:0] total_next;

  gws_pkg::gws_taps_t taps;

  logic          item_accept;
  logic          s1_move;
  logic          cfg_write;
  logic [EW-1:0] rw_ext;
  logic [EW-1:0] eff_width;
  logic          row_end;
  logic [3:0]    hits;
  logic [gws_pkg::TOTAL_W:0] total_sum;

  // Handshake
  assign s1_move     = s1_valid && (!result_valid || !result_stall);
  assign item_stall  = s1_valid && !s1_move;
  assign item_accept = item_valid && !item_stall;

  // Configuration writes and reads
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= gws_pkg::ROW_WIDTH_RST;
      word.first  <= gws_pkg::FIRST_RST;
      word.second <= gws_pkg::SECOND_RST;
      word.third  <= gws_pkg::THIRD_RST;
      word.fourth <= gws_pkg::FOURTH_RST;
    end else if (cfg_write) begin
      case (gws_pkg::gws_reg_t'(paddr[4:2]))
        gws_pkg::REG_ROW_WIDTH: row_width   <= pwdata[8:0];
        gws_pkg::REG_FIRST:     word.first  <= pwdata[7:0];
        gws_pkg::REG_SECOND:    word.second <= pwdata[7:0];
        gws_pkg::REG_THIRD:     word.third  <= pwdata[7:0];
        gws_pkg::REG_FOURTH:    word.fourth <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gws_pkg::gws_reg_t'(paddr[4:2]))
      gws_pkg::REG_ROW_WIDTH: prdata = 32'(row_width);
      gws_pkg::REG_FIRST:     prdata = 32'(word.first);
      gws_pkg::REG_SECOND:    prdata = 32'(word.second);
      gws_pkg::REG_THIRD:     prdata = 32'(word.third);
      gws_pkg::REG_FOURTH:    prdata = 32'(word.fourth);
      default:                prdata = '0;
    endcase
  end

  // Row width clamped to the range the line stores support
  assign rw_ext = EW'(row_width);

  always_comb begin
    if (rw_ext < EW'(gws_pkg::MIN_WIDTH)) begin
      eff_width = EW'(gws_pkg::MIN_WIDTH);
    end else if (rw_ext > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = rw_ext;
    end
  end

  assign row_end = (EW'(column_index) + EW'(1)) >= eff_width;

  // Column and row counters move with each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      rows_seen    <= '0;
    end else if (item_accept) begin
      if (last_of_frame) begin
        column_index <= '0;
        rows_seen    <= '0;
      end else if (row_end) begin
        column_index <= '0;
        if (rows_seen != gws_pkg::ROWS_FULL) begin
          rows_seen <= rows_seen + 2'd1;
        end
      end else begin
        column_index <= column_index + CW'(1);
      end
    end
  end

  // Input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_symbol <= symbol;
      s1_last   <= last_of_frame;
      s1_col    <= column_index;
      s1_rows3  <= (rows_seen == gws_pkg::ROWS_FULL);
    end
  end

  // Line stores, read on acceptance and written as the request completes
  gws_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (item_accept),
    .rd_addr   (column_index),
    .wr_en     (s1_move),
    .wr_col    (s1_col),
    .wr_symbol (s1_symbol),
    .taps      (taps)
  );

  // Window shifted left with the new column on the right
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 3; m++) begin
        window_next[k][m] = window[k][m+1];
      end
    end
    window_next[0][3] = s1_symbol;
    window_next[1][3] = taps.above[7:0];
    window_next[2][3] = taps.above[15:8];
    window_next[3][3] = taps.above[23:16];
  end

  // Matches ending at this cell: left, up, up-left and up-right lines
  always_comb begin
    hits = '0;
    if (s1_col >= CW'(gws_pkg::WORD_REACH)) begin
      hits = hits + 4'(gws_pkg::both_ways(window_next[0][0], window_next[0][1],
                                          window_next[0][2], window_next[0][3], word));
    end
    if (s1_rows3) begin
      hits = hits + 4'(gws_pkg::both_ways(window_next[3][3], window_next[2][3],
                                          window_next[1][3], window_next[0][3], word));
      if (s1_col >= CW'(gws_pkg::WORD_REACH)) begin
        hits = hits + 4'(gws_pkg::both_ways(window_next[3][0], window_next[2][1],
                                            window_next[1][2], window_next[0][3], word));
      end
      if ((SW'(s1_col) + SW'(gws_pkg::WORD_REACH)) < SW'(eff_width)) begin
        hits = hits + 4'(gws_pkg::both_ways(taps.diag[23:16], taps.diag[15:8],
                                            taps.diag[7:0], s1_symbol, word));
      end
    end
  end

  // Saturating frame total
  assign total_sum  = {1'b0, total_count} + (gws_pkg::TOTAL_W + 1)'(hits);
  assign total_next = total_sum[gws_pkg::TOTAL_W] ? gws_pkg::TOTAL_MAX
                                                  : total_sum[gws_pkg::TOTAL_W-1:0];

  // Frame state, cleared after the last symbol of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      for (int k = 0; k < 4; k++) begin
        for (int m = 0; m < 4; m++) begin
          window[k][m] <= '0;
        end
      end
    end else if (s1_move) begin
      if (s1_last) begin
        total_count <= '0;
        for (int k = 0; k < 4; k++) begin
          for (int m = 0; m < 4; m++) begin
            window[k][m] <= '0;
          end
        end
      end else begin
        total_count <= total_next;
        window      <= window_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      matches_here  <= hits;
      running_total <= total_next;
      frame_done    <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // At most eight lines can end at one cell.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (matches_here <= 4'd8))
    else $error("matches_here above eight");

  // Within a frame the total never falls.
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_last) |=> (total_count >= $past(total_count)))
    else $error("frame total decreased");

  // The last symbol of a frame leaves the total cleared.
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_last) |=> (total_count == '0))
    else $error("total not cleared at frame end");

  // The row counter stays saturated until the frame ends.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && !last_of_frame && (rows_seen == gws_pkg::ROWS_FULL))
      |=> (rows_seen == gws_pkg::ROWS_FULL))
    else $error("row counter left saturation");

  // A result is only offered once the input stage has handed one over.
  assert property (@(posedge clk) disable iff (rst)
    (!result_valid && !s1_valid) |=> !result_valid)
    else $error("result raised without a request");
`endif

endmodule
